// ----- hw/rtl/wfrr_pkg.sv -----
// Shared types and constants of the wildcard flow rule rewrite block.
package wfrr_pkg;

    localparam int RULE_SLOTS = 16;
    localparam int IDX_W      = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
    localparam int CNT_W      = $clog2(RULE_SLOTS + 1);
    localparam int IN_DATA_W  = 192;
    localparam int OUT_DATA_W = 96;

    typedef enum logic {
        CMD_LOOKUP = 1'b0,
        CMD_ADD    = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_HIT   = 2'd0,
        ST_MISS  = 2'd1,
        ST_ADDED = 2'd2,
        ST_FULL  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIN
    } t_state;

    typedef struct packed {
        logic [15:0] dport;
        logic [31:0] dst_ip;
        logic [15:0] sport;
        logic [31:0] src_ip;
    } t_tuple;

    typedef struct packed {
        t_tuple action;
        t_tuple pattern;
    } t_rule;

    typedef struct packed {
        logic   hit;
        t_tuple rw;
    } t_match;

endpackage

// ----- hw/rtl/wfrr_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module wfrr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                          i_clk,
    input  logic                                          i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_waddr,
    input  logic [WIDTH-1:0]                              i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_raddr,
    output logic [WIDTH-1:0]                              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/wfrr_match.sv -----
// Wildcard compare of a packet tuple against one rule, and field rewrite.
module wfrr_match (
    input  wfrr_pkg::t_tuple i_key,
    input  wfrr_pkg::t_rule  i_rule,
    output wfrr_pkg::t_match o_match
);
    import wfrr_pkg::*;

    t_tuple w_pat;
    t_tuple w_act;

    assign w_pat = i_rule.pattern;
    assign w_act = i_rule.action;

    always_comb begin
        o_match.hit = ((w_pat.src_ip == '0) || (w_pat.src_ip == i_key.src_ip)) &&
                      ((w_pat.sport  == '0) || (w_pat.sport  == i_key.sport))  &&
                      ((w_pat.dst_ip == '0) || (w_pat.dst_ip == i_key.dst_ip)) &&
                      ((w_pat.dport  == '0) || (w_pat.dport  == i_key.dport));
        o_match.rw.src_ip = (w_act.src_ip == '0) ? i_key.src_ip : w_act.src_ip;
        o_match.rw.sport  = (w_act.sport  == '0) ? i_key.sport  : w_act.sport;
        o_match.rw.dst_ip = (w_act.dst_ip == '0) ? i_key.dst_ip : w_act.dst_ip;
        o_match.rw.dport  = (w_act.dport  == '0) ? i_key.dport  : w_act.dport;
    end

endmodule

// ----- hw/rtl/wildcard_flow_rule_rewrite.sv -----
// Wildcard four-tuple flow rule table with address and port rewrite.
//
// Input channel s_axis: one request per handshake. tuser is the command
// (0 lookup, 1 add rule); tdata carries the tuple and, for an add, the action.
// Output channel m_axis: one result per request. tuser is the status
// (0 hit, 1 miss, 2 rule added, 3 table full); tdata the rewritten tuple,
// zero unless the status is hit.
// An add is answered without a scan. A lookup scans the stored
// rules newest first, one rule per cycle out of the rule RAM (one read port,
// registered read data, first read issued at acceptance), visiting at most
// RULE_SLOTS rules. An empty table answers without a scan. One request is
// in work at a time; the next one is taken the cycle after the result enters
// the output register.
// Reset empties the table at once (the rule count returns to zero, no
// clearing pass) and drops any pending result. When the receiver stalls,
// the output register holds its result and at most one further result waits
// inside; the input channel then stops taking requests.
module wildcard_flow_rule_rewrite (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // src_ip, sport, dst_ip, dport, rw_src_ip, rw_sport,
    // rw_dst_ip, rw_dport
    input  logic [wfrr_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // command
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // out_src_ip, out_sport, out_dst_ip, out_dport
    output logic [wfrr_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // status
    output logic [1:0]                         m_axis_tuser
);
    import wfrr_pkg::*;

    t_state          r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [IDX_W-1:0] r_idx,   n_idx;
    t_tuple          r_key,   n_key;
    t_status         r_res_status, n_res_status;
    t_tuple          r_res_tuple,  n_res_tuple;
    logic            r_out_valid,  n_out_valid;
    t_status         r_out_status, n_out_status;
    t_tuple          r_out_tuple,  n_out_tuple;

    logic             w_acc;
    t_cmd             w_cmd;
    t_tuple           w_in_key;
    t_tuple           w_in_act;
    t_rule            w_wdata;
    t_rule            w_rdata;
    logic             w_we;
    logic [IDX_W-1:0] w_raddr;
    t_match           w_match;

    assign w_acc = s_axis_tvalid && s_axis_tready;
    assign w_cmd = t_cmd'(s_axis_tuser);

    assign w_in_key.src_ip = s_axis_tdata[31:0];
    assign w_in_key.sport  = s_axis_tdata[47:32];
    assign w_in_key.dst_ip = s_axis_tdata[79:48];
    assign w_in_key.dport  = s_axis_tdata[95:80];
    assign w_in_act.src_ip = s_axis_tdata[127:96];
    assign w_in_act.sport  = s_axis_tdata[143:128];
    assign w_in_act.dst_ip = s_axis_tdata[175:144];
    assign w_in_act.dport  = s_axis_tdata[191:176];

    assign w_wdata.pattern = w_in_key;
    assign w_wdata.action  = w_in_act;

    wfrr_ram #(
        .WIDTH ($bits(t_rule)),
        .DEPTH (RULE_SLOTS)
    ) u_rule_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    wfrr_match u_match (
        .i_key   (r_key),
        .i_rule  (w_rdata),
        .o_match (w_match)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {r_out_tuple.dport, r_out_tuple.dst_ip,
                            r_out_tuple.sport, r_out_tuple.src_ip};

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_key        = r_key;
        n_res_status = r_res_status;
        n_res_tuple  = r_res_tuple;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_status = r_out_status;
        n_out_tuple  = r_out_tuple;
        w_we         = 1'b0;
        w_raddr      = r_idx;

        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_key       = w_in_key;
                    n_res_tuple = '0;
                    n_state     = S_FIN;
                    if (w_cmd == CMD_ADD) begin
                        if (r_count == CNT_W'(RULE_SLOTS)) begin
                            n_res_status = ST_FULL;
                        end else begin
                            w_we         = 1'b1;
                            n_count      = r_count + CNT_W'(1);
                            n_res_status = ST_ADDED;
                        end
                    end else if (r_count == '0) begin
                        n_res_status = ST_MISS;
                    end else begin
                        n_idx   = IDX_W'(r_count - CNT_W'(1));
                        w_raddr = n_idx;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (w_match.hit) begin
                    n_res_status = ST_HIT;
                    n_res_tuple  = w_match.rw;
                    n_state      = S_FIN;
                end else if (r_idx == '0) begin
                    n_res_status = ST_MISS;
                    n_res_tuple  = '0;
                    n_state      = S_FIN;
                end else begin
                    n_idx   = r_idx - IDX_W'(1);
                    w_raddr = n_idx;
                end
            end
            S_FIN: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_tuple  = r_res_tuple;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_key        <= n_key;
        r_res_status <= n_res_status;
        r_res_tuple  <= n_res_tuple;
        r_out_status <= n_out_status;
        r_out_tuple  <= n_out_tuple;
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(RULE_SLOTS))
        else $error("rule count beyond table size");

    a_add_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_cmd == CMD_ADD && r_count != CNT_W'(RULE_SLOTS))
        |=> (r_count == $past(r_count) + CNT_W'(1)) && (r_res_status == ST_ADDED))
        else $error("accepted add did not store a rule");

    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !w_we)
        else $error("rule RAM written during a scan");

    a_hit_needs_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && r_res_status == ST_HIT) |-> (r_count != '0))
        else $error("hit reported with an empty table");
`endif

endmodule

// ----- bench/wildcard_flow_rule_rewrite_tb.sv -----
// Self-checking stream testbench for the wildcard flow rule rewrite table.
`timescale 1ns / 100ps

module wildcard_flow_rule_rewrite_tb;

    import wfrr_pkg::*;

    typedef struct {
        t_cmd  cmd;
        t_rule body;
    } t_request;

    typedef struct {
        t_status status;
        t_tuple  rw;
    } t_answer;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  s_axis_tuser  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [1:0]            m_axis_tuser;

    t_request requests_pending[$];
    t_answer  answers_due[$];
    t_request in_flight;

    t_rule    rule_table[RULE_SLOTS];
    int       rule_count = 0;
    t_tuple   gen_patterns[RULE_SLOTS];
    int       gen_count = 0;

    int       n_accepted = 0;
    int       n_mismatch = 0;
    logic     hold_off = 1'b0;

    wildcard_flow_rule_rewrite DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // src_ip, sport, dst_ip, dport, rw_* in same order
        .s_axis_tuser  (s_axis_tuser),   // command
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // out_src_ip, out_sport, out_dst_ip, out_dport
        .m_axis_tuser  (m_axis_tuser)    // status
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_answer rule_table_answer(t_cmd cmd, t_rule req);
        t_answer ans;
        t_tuple  pat;
        t_tuple  act;
        int      k;
        ans.status = ST_MISS;
        ans.rw     = '0;
        if (cmd == CMD_ADD) begin
            if (rule_count >= RULE_SLOTS) begin
                ans.status = ST_FULL;
            end else begin
                rule_table[rule_count] = req;
                rule_count++;
                ans.status = ST_ADDED;
            end
        end else begin
            k = rule_count - 1;
            while (k >= 0 && ans.status == ST_MISS) begin
                pat = rule_table[k].pattern;
                act = rule_table[k].action;
                if ((pat.src_ip == 0 || pat.src_ip == req.pattern.src_ip) &&
                    (pat.sport == 0 || pat.sport == req.pattern.sport) &&
                    (pat.dst_ip == 0 || pat.dst_ip == req.pattern.dst_ip) &&
                    (pat.dport == 0 || pat.dport == req.pattern.dport)) begin
                    ans.status = ST_HIT;
                    ans.rw.src_ip = (act.src_ip == 0) ? req.pattern.src_ip : act.src_ip;
                    ans.rw.sport  = (act.sport == 0) ? req.pattern.sport : act.sport;
                    ans.rw.dst_ip = (act.dst_ip == 0) ? req.pattern.dst_ip : act.dst_ip;
                    ans.rw.dport  = (act.dport == 0) ? req.pattern.dport : act.dport;
                end
                k--;
            end
        end
        return ans;
    endfunction

    function automatic logic [31:0] pick_ip();
        case ($urandom_range(7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] pick_port();
        case ($urandom_range(7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    function automatic t_tuple any_tuple();
        t_tuple t;
        t.src_ip = pick_ip();
        t.sport  = pick_port();
        t.dst_ip = pick_ip();
        t.dport  = pick_port();
        return t;
    endfunction

    function automatic t_tuple sparse_tuple();
        t_tuple t;
        t = any_tuple();
        if ($urandom_range(1)) t.src_ip = '0;
        if ($urandom_range(1)) t.sport = '0;
        if ($urandom_range(1)) t.dst_ip = '0;
        if ($urandom_range(1)) t.dport = '0;
        return t;
    endfunction

    function automatic t_tuple tuple_for(t_tuple pat);
        t_tuple t;
        t = any_tuple();
        if (pat.src_ip != 0) t.src_ip = pat.src_ip;
        if (pat.sport != 0) t.sport = pat.sport;
        if (pat.dst_ip != 0) t.dst_ip = pat.dst_ip;
        if (pat.dport != 0) t.dport = pat.dport;
        return t;
    endfunction

    function automatic int sender_idle_pct();
        case ((n_accepted / 150) % 4)
            1:       return 63;
            3:       return 23;
            default: return 0;
        endcase
    endfunction

    function automatic int receiver_stall_pct();
        case ((n_accepted / 150) % 4)
            2:       return 63;
            3:       return 23;
            default: return 0;
        endcase
    endfunction

    task automatic queue_request(t_cmd cmd, t_tuple tup, t_tuple act);
        t_request r;
        r.cmd          = cmd;
        r.body.pattern = tup;
        r.body.action  = act;
        requests_pending.push_back(r);
        if (cmd == CMD_ADD && gen_count < RULE_SLOTS) begin
            gen_patterns[gen_count] = tup;
            gen_count++;
        end
    endtask

    task automatic log_mismatch(string what, t_answer want);
        n_mismatch++;
        if (n_mismatch <= 10) begin
            $display("%0t mismatch (%s): expected status %0d tuple %h, got status %0d tuple %h",
                     $realtime, what, want.status, want.rw, m_axis_tuser, m_axis_tdata);
        end
    endtask

    always @(posedge i_clk) begin : drive_requests
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                answers_due.push_back(rule_table_answer(in_flight.cmd, in_flight.body));
                n_accepted <= n_accepted + 1;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (requests_pending.size() != 0 &&
                    $urandom_range(99) >= sender_idle_pct()) begin
                    in_flight = requests_pending.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= in_flight.body;
                    s_axis_tuser  <= in_flight.cmd;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : pace_results
        if (!i_rst_n || hold_off) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct());
        end
    end

    always @(posedge i_clk) begin : check_results
        t_answer want;
        t_tuple  got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (answers_due.size() == 0) begin
                want.status = ST_MISS;
                want.rw     = '0;
                log_mismatch("no request waiting", want);
            end else begin
                want = answers_due.pop_front();
                if (m_axis_tuser !== want.status ||
                    got.src_ip !== want.rw.src_ip || got.sport !== want.rw.sport ||
                    got.dst_ip !== want.rw.dst_ip || got.dport !== want.rw.dport) begin
                    log_mismatch("field", want);
                end
            end
        end
    end

    initial begin : long_hold_off
        wait (n_accepted >= 700);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (400) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin : run_limit
        #3_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin : stimulus
        t_tuple zeros;
        t_tuple ones;
        t_tuple tup;
        t_tuple act;
        int     roll;
        zeros = '0;
        ones  = '1;

        // empty table, extremes, newest-first fallback, wildcards and keep-original actions
        queue_request(CMD_LOOKUP, zeros, zeros);
        queue_request(CMD_LOOKUP, ones, ones);
        queue_request(CMD_ADD, ones, ones);
        queue_request(CMD_LOOKUP, ones, zeros);
        tup = ones;
        tup.dport = 16'hFFFE;
        queue_request(CMD_LOOKUP, tup, any_tuple());
        tup = zeros;
        tup.src_ip = 32'h0A00_0001;
        act = zeros;
        act.sport = 16'h1234;
        queue_request(CMD_ADD, tup, act);
        queue_request(CMD_LOOKUP, tuple_for(tup), any_tuple());
        queue_request(CMD_LOOKUP, ones, zeros);
        tup = zeros;
        tup.dport = 16'hFFFF;
        act = zeros;
        act.dst_ip = 32'h0000_0001;
        queue_request(CMD_ADD, tup, act);
        queue_request(CMD_LOOKUP, ones, ones);
        tup = zeros;
        tup.sport  = 16'd80;
        tup.dst_ip = 32'hC0A8_0001;
        act = any_tuple();
        queue_request(CMD_ADD, tup, act);
        queue_request(CMD_LOOKUP, tuple_for(tup), zeros);
        tup = tuple_for(tup);
        tup.sport = 16'd81;
        queue_request(CMD_LOOKUP, tup, ones);
        queue_request(CMD_LOOKUP, zeros, any_tuple());

        repeat (1136) begin
            roll = $urandom_range(99);
            if (roll < 4) begin
                queue_request(CMD_ADD, sparse_tuple(), sparse_tuple());
            end else if (roll < 74) begin
                tup = tuple_for(gen_patterns[$urandom_range(gen_count - 1)]);
                queue_request(CMD_LOOKUP, tup, any_tuple());
            end else if (roll < 86) begin
                tup = tuple_for(gen_patterns[$urandom_range(gen_count - 1)]);
                case ($urandom_range(3))
                    0: tup.src_ip = $urandom;
                    1: tup.sport  = 16'($urandom_range(65535));
                    2: tup.dst_ip = $urandom;
                    default: tup.dport = 16'($urandom_range(65535));
                endcase
                queue_request(CMD_LOOKUP, tup, any_tuple());
            end else begin
                queue_request(CMD_LOOKUP, any_tuple(), any_tuple());
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (requests_pending.size() != 0 || s_axis_tvalid || answers_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (40) @(posedge i_clk);
        if (n_mismatch == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
